// ===== rtl/core/clm_pkg.sv =====
// shared types, constants and codes of the channel level meter
package clm_pkg;

    // defaults of the top-level parameters
    localparam int DEF_CHANNELS  = 64;
    localparam int DEF_MAX_BLOCK = 4096;

    // field widths
    localparam int CH_W       = 6;
    localparam int NUM_CH_CODES = 64;
    localparam int SAMPLE_W   = 24;
    localparam int LEVEL_W    = 24;
    localparam int FACTOR_W   = 16;
    localparam int COUNT_W    = 32;
    localparam int POS_W      = 48;
    localparam int ARM_W      = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;

    // square of a sample is at most 2^46
    localparam int SQ_W   = 47;
    localparam int ROOT_W = 24;
    localparam int RAD_W  = 2 * ROOT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_MASK   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_THRESH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DECAY = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_DECAY  = 4'd3;

    // register reset values
    localparam logic [ARM_W-1:0]    RST_ARM_MASK    = '0;
    localparam logic [LEVEL_W-1:0]  RST_CLIP_THRESH = 24'd8380219;
    localparam logic [FACTOR_W-1:0] RST_PEAK_DECAY  = 16'd60293;
    localparam logic [FACTOR_W-1:0] RST_RMS_DECAY   = 16'd55706;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SQ_LOAD,
        ST_SQRT,
        ST_DEC_RMS,
        ST_WRITE
    } clm_state_t;

    // per-channel meter record
    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] rms;
        logic               clip;
        logic [COUNT_W-1:0] clip_count;
        logic [POS_W-1:0]   clip_pos;
    } clm_entry_t;

    typedef struct packed {
        logic capture;
        logic accum;
        logic div_init;
        logic div_step;
        logic sq_init;
        logic sq_step;
        logic dec_peak_ld;
        logic dec_rms_ld;
        logic finish;
    } clm_cmd_t;

    typedef struct packed {
        logic in_range;
        logic last;
        logic armed;
        logic div_last;
        logic sq_last;
        logic out_free;
    } clm_status_t;

endpackage

// ===== rtl/core/channel_level_meter.sv =====
// top level of the multichannel peak and rms level meter
//
// channel   dir  handshake          payload
// s_        in   s_valid / s_ready  s_channel, s_sample, s_block_end, s_position
// m_        out  m_valid / m_ready  m_meter_channel, m_peak_level, m_rms_level,
//                                   m_clip_flag, m_clip_total, m_last_clip_at
// cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// a sample that does not end a block passes capture and accumulate; a transaction
// for a channel at or beyond CHANNELS is captured only and leaves the sequencer idle
// an armed block end goes on through the bit-serial divider (SUM_W steps) and the square
// root (24 steps); a disarmed one through the rms decay, and both then to the write step
// synchronous active-low reset clears the valid bits of the channel store at once
// a block end waits in its write step while the previous result is not taken
module channel_level_meter
    import clm_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // sample transactions
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CH_W-1:0]       s_channel,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                  s_block_end,
    input  logic [POS_W-1:0]      s_position,
    // meter transactions
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_meter_channel,
    output logic [LEVEL_W-1:0]    m_peak_level,
    output logic [LEVEL_W-1:0]    m_rms_level,
    output logic                  m_clip_flag,
    output logic [COUNT_W-1:0]    m_clip_total,
    output logic [POS_W-1:0]      m_last_clip_at
);

    clm_cmd_t    cmd;
    clm_status_t st;

    // sequencer: accepts transactions and steps the datapath
    clm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // accumulators, divider, square root, decay, channel store and result register
    clm_datapath #(
        .CHANNELS  (CHANNELS),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_channel       (s_channel),
        .s_sample        (s_sample),
        .s_block_end     (s_block_end),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_meter_channel (m_meter_channel),
        .m_peak_level    (m_peak_level),
        .m_rms_level     (m_rms_level),
        .m_clip_flag     (m_clip_flag),
        .m_clip_total    (m_clip_total),
        .m_last_clip_at  (m_last_clip_at),
        .cmd             (cmd),
        .st              (st)
    );

    // ready drops after an in-range transaction is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (int'(s_channel) < CHANNELS)) |=> !s_ready)
        else $error("ready did not drop after an in-range transaction");

    // a nonzero clip count implies the sticky flag
    a_clip_flag_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_clip_total != '0)) |-> m_clip_flag)
        else $error("clip count without clip flag");

    // the rms of full-scale samples never exceeds full scale
    a_rms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rms_level <= 24'h800000))
        else $error("rms level beyond full scale");

    // held peak stays within full scale
    a_peak_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_peak_level <= 24'h800000))
        else $error("peak level beyond full scale");

endmodule

// ===== rtl/core/clm_ctrl.sv =====
// sequencer of the channel level meter
module clm_ctrl
    import clm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  clm_status_t st,
    output clm_cmd_t    cmd
);

    clm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (st.in_range) begin
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                cmd.accum = 1'b1;
                if (!st.last) begin
                    state_next = ST_IDLE;
                end else if (st.armed) begin
                    state_next = ST_DIV_LOAD;
                end else begin
                    state_next = ST_DEC_RMS;
                    cmd.dec_peak_ld = 1'b1;
                end
            end
            ST_DIV_LOAD: begin
                cmd.div_init    = 1'b1;
                cmd.dec_peak_ld = 1'b1;
                state_next      = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = ST_SQ_LOAD;
                end
            end
            ST_SQ_LOAD: begin
                cmd.sq_init = 1'b1;
                state_next  = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sq_step = 1'b1;
                if (st.sq_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_DEC_RMS: begin
                cmd.dec_rms_ld = 1'b1;
                state_next     = ST_WRITE;
            end
            ST_WRITE: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/clm_datapath.sv =====
// accumulators, divider, square root, decay and channel store of the meter
module clm_datapath
    import clm_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [CH_W-1:0]       s_channel,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                  s_block_end,
    input  logic [POS_W-1:0]      s_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_meter_channel,
    output logic [LEVEL_W-1:0]    m_peak_level,
    output logic [LEVEL_W-1:0]    m_rms_level,
    output logic                  m_clip_flag,
    output logic [COUNT_W-1:0]    m_clip_total,
    output logic [POS_W-1:0]      m_last_clip_at,
    input  clm_cmd_t              cmd,
    output clm_status_t           st
);

    localparam int DEPTH  = (CHANNELS > NUM_CH_CODES) ? NUM_CH_CODES : CHANNELS;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W  = SQ_W + $clog2(MAX_BLOCK);
    localparam int ITER_W = $clog2(SUM_W);

    // configuration
    logic [ARM_W-1:0]    arm_mask_reg;
    logic [LEVEL_W-1:0]  clip_thresh_reg;
    logic [FACTOR_W-1:0] peak_decay_reg;
    logic [FACTOR_W-1:0] rms_decay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_mask_reg    <= RST_ARM_MASK;
            clip_thresh_reg <= RST_CLIP_THRESH;
            peak_decay_reg  <= RST_PEAK_DECAY;
            rms_decay_reg   <= RST_RMS_DECAY;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ARM_MASK:    arm_mask_reg    <= cfg_wdata;
                CFG_CLIP_THRESH: clip_thresh_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_PEAK_DECAY:  peak_decay_reg  <= cfg_wdata[FACTOR_W-1:0];
                CFG_RMS_DECAY:   rms_decay_reg   <= cfg_wdata[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    // captured transaction
    logic [CH_W-1:0]     ch_reg;
    logic                last_reg;
    logic                armed_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [LEVEL_W-1:0]  mag_reg;

    logic                in_range;
    logic [IDX_W-1:0]    idx_in;
    logic [IDX_W-1:0]    idx_reg;
    logic signed [SAMPLE_W:0] samp_x;
    logic signed [SAMPLE_W:0] samp_abs;
    logic signed [2*SAMPLE_W-1:0] samp_sq;

    assign in_range = int'(s_channel) < CHANNELS;
    assign idx_in   = s_channel[IDX_W-1:0];
    assign idx_reg  = ch_reg[IDX_W-1:0];
    assign samp_x   = (SAMPLE_W + 1)'(s_sample);
    assign samp_abs = samp_x[SAMPLE_W] ? -samp_x : samp_x;
    assign samp_sq  = s_sample * s_sample;

    // channel store with a valid bit per entry
    clm_entry_t          mem [DEPTH];
    logic [DEPTH-1:0]    ent_valid_reg;
    clm_entry_t          rd_reg;
    logic                rd_valid_reg;
    clm_entry_t          ent;
    clm_entry_t          new_ent;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_reg    <= s_channel;
            last_reg  <= s_block_end;
            armed_reg <= arm_mask_reg[s_channel];
            pos_reg   <= s_position;
            sq_reg    <= samp_sq[SQ_W-1:0];
            mag_reg   <= samp_abs[LEVEL_W-1:0];
            if (in_range) begin
                rd_reg       <= mem[idx_in];
                rd_valid_reg <= ent_valid_reg[idx_in];
            end
        end
        if (cmd.finish) begin
            mem[idx_reg] <= new_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
        end else if (cmd.finish) begin
            ent_valid_reg[idx_reg] <= 1'b1;
        end
    end

    assign ent = rd_valid_reg ? rd_reg : '0;

    // block accumulators
    logic [LEVEL_W-1:0] bpeak_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               gather;

    assign gather = cmd.accum && armed_reg && (count_reg < CNT_W'(MAX_BLOCK));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpeak_reg <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (cmd.finish) begin
            bpeak_reg <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (gather) begin
            if (mag_reg > bpeak_reg) begin
                bpeak_reg <= mag_reg;
            end
            sum_reg   <= sum_reg + SUM_W'(sq_reg);
            count_reg <= count_reg + 1'b1;
        end
    end

    // restoring divider then digit-by-digit square root, one shared counter
    logic [ITER_W-1:0]  iter_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dvsr_reg;
    logic [CNT_W:0]     div_trial;
    logic               div_fit;
    logic [RAD_W-1:0]   rad_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [ROOT_W+1:0]  srem_reg;
    logic [ROOT_W+3:0]  sq_shift;
    logic [ROOT_W+3:0]  sq_trial;
    logic               sq_fit;

    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    assign div_fit   = div_trial >= {1'b0, dvsr_reg};
    assign sq_shift  = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial  = (ROOT_W + 4)'({root_reg, 2'b01});
    assign sq_fit    = sq_shift >= sq_trial;

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            iter_reg <= '0;
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            dvsr_reg <= (count_reg == '0) ? CNT_W'(1) : count_reg;
        end else if (cmd.div_step) begin
            iter_reg <= iter_reg + 1'b1;
            quo_reg  <= {quo_reg[SUM_W-2:0], div_fit};
            rem_reg  <= div_fit ? CNT_W'(div_trial - {1'b0, dvsr_reg})
                                : div_trial[CNT_W-1:0];
        end else if (cmd.sq_init) begin
            iter_reg <= '0;
            rad_reg  <= RAD_W'(quo_reg);
            root_reg <= '0;
            srem_reg <= '0;
        end else if (cmd.sq_step) begin
            iter_reg <= iter_reg + 1'b1;
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], sq_fit};
            srem_reg <= sq_fit ? (ROOT_W + 2)'(sq_shift - sq_trial)
                               : (ROOT_W + 2)'(sq_shift);
        end
    end

    // one multiplier for both decays
    logic [LEVEL_W-1:0]          mul_a;
    logic [FACTOR_W-1:0]         mul_b;
    logic [LEVEL_W+FACTOR_W-1:0] mul_p;
    logic [LEVEL_W-1:0]          dpeak_reg;
    logic [LEVEL_W-1:0]          drms_reg;

    assign mul_a = cmd.dec_rms_ld ? ent.rms : ent.peak;
    assign mul_b = cmd.dec_rms_ld ? rms_decay_reg : peak_decay_reg;
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.dec_peak_ld) begin
            dpeak_reg <= mul_p[LEVEL_W+FACTOR_W-1:FACTOR_W];
        end
        if (cmd.dec_rms_ld) begin
            drms_reg <= mul_p[LEVEL_W+FACTOR_W-1:FACTOR_W];
        end
    end

    // updated record
    logic clipped;

    assign clipped = bpeak_reg >= clip_thresh_reg;

    always_comb begin
        new_ent = ent;
        if (armed_reg) begin
            new_ent.peak = (bpeak_reg > dpeak_reg) ? bpeak_reg : dpeak_reg;
            new_ent.rms  = root_reg;
            if (clipped) begin
                new_ent.clip     = 1'b1;
                new_ent.clip_pos = pos_reg;
                if (ent.clip_count != '1) begin
                    new_ent.clip_count = ent.clip_count + 1'b1;
                end
            end
        end else begin
            new_ent.peak = dpeak_reg;
            new_ent.rms  = drms_reg;
        end
    end

    // result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_meter_channel <= ch_reg;
            m_peak_level    <= new_ent.peak;
            m_rms_level     <= new_ent.rms;
            m_clip_flag     <= new_ent.clip;
            m_clip_total    <= new_ent.clip_count;
            m_last_clip_at  <= new_ent.clip_pos;
        end
    end

    assign m_valid = m_valid_reg;

    assign st.in_range = in_range;
    assign st.last     = last_reg;
    assign st.armed    = armed_reg;
    assign st.div_last = iter_reg == ITER_W'(SUM_W - 1);
    assign st.sq_last  = iter_reg == ITER_W'(ROOT_W - 1);
    assign st.out_free = !m_valid_reg || m_ready;

endmodule
